// File: hdl/mf5_pkg.sv
// Shared types, constants and the five-input median function of the median filter.
package mf5_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int MAX_BLOCK = 512;
  localparam int POS_W     = $clog2(MAX_BLOCK + 1);
  localparam int NET_LEN   = 9;
  localparam int SLOTS     = 3;
  localparam int CNT_W     = $clog2(SLOTS + 1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [POS_W-1:0]           pos_t;
  typedef logic [CNT_W-1:0]           cnt_t;

  typedef struct packed {
    sample_t value;
    logic    done;
  } result_t;

  // Optimal 9-comparator sorting network for five inputs.
  localparam int NET_LO [NET_LEN] = '{0, 3, 2, 2, 1, 0, 0, 1, 1};
  localparam int NET_HI [NET_LEN] = '{1, 4, 4, 3, 4, 3, 2, 3, 2};

  function automatic sample_t median5(sample_t a, sample_t b, sample_t c,
                                      sample_t d, sample_t e);
    sample_t w [5];
    sample_t t;
    w[0] = a;
    w[1] = b;
    w[2] = c;
    w[3] = d;
    w[4] = e;
    for (int k = 0; k < NET_LEN; k++) begin
      if (w[NET_LO[k]] > w[NET_HI[k]]) begin
        t            = w[NET_LO[k]];
        w[NET_LO[k]] = w[NET_HI[k]];
        w[NET_HI[k]] = t;
      end
    end
    return w[2];
  endfunction

endpackage

// File: hdl/mf5_in_if.sv
// Input sample channel: valid/ready plus sample and block end flag.
interface mf5_in_if;
  logic             valid;
  logic             ready;
  mf5_pkg::sample_t sample_in;
  logic             block_end;

  modport source (output valid, output sample_in, output block_end, input ready);
  modport sink   (input valid, input sample_in, input block_end, output ready);
endinterface

// File: hdl/mf5_out_if.sv
// Result channel: valid/ready plus filtered sample and block done flag.
interface mf5_out_if;
  logic             valid;
  logic             ready;
  mf5_pkg::sample_t sample_out;
  logic             block_done;

  modport source (output valid, output sample_out, output block_done, input ready);
  modport sink   (input valid, input sample_out, input block_done, output ready);
endinterface

// File: hdl/median_filter_5tap.sv
// Five-tap streaming median filter over blocks of signed 16-bit samples.
//
// samples: one request per input sample; block_end marks the last sample of a block.
// results: filtered samples in order; block_done marks the last result of a block.
// Each sample is replaced by the median of the five samples centred on it, with the
// block's first/last sample repeated at the edges. Output lags input by two samples,
// so the sample with block_end (or the 512th of a block) releases one, two or three results.
// Samples past the 512th of a block pass through unchanged.
// A request is registered in the input stage; its medians are computed from that stage and
// loaded into a three-entry result buffer once it is free, and the buffer presents the results.
// Throughput: one sample per cycle while results are taken; an item that releases several
// results holds the result buffer until its last result is being delivered, so sustained
// rate is set by the result port at one result per cycle.
// Reset clears the history, position count, input stage and result buffer.
// When results stalls, the buffer holds and samples.ready drops once the input stage
// is also full; nothing is dropped.
module median_filter_5tap (
  input  logic      clk,
  input  logic      rst,
  mf5_in_if.sink    samples,
  mf5_out_if.source results
);

  // history and block position, updated at accept
  mf5_pkg::sample_t hist [4];
  mf5_pkg::pos_t    pos;

  // input stage
  logic             s1_valid;
  mf5_pkg::sample_t s1_x;
  mf5_pkg::sample_t s1_h [4];
  logic             s1_last;
  logic             s1_pass;
  logic             s1_ge1;
  logic             s1_ge2;
  logic             s1_lim;

  // result buffer
  mf5_pkg::result_t slot [mf5_pkg::SLOTS];
  mf5_pkg::cnt_t    cnt;

  logic             accept;
  logic             pop;
  logic             buf_free;
  logic             s1_adv;
  logic             load;
  logic             at_start;
  logic             past_lim;
  mf5_pkg::sample_t med_a;
  mf5_pkg::sample_t med_b;
  mf5_pkg::sample_t med_c;
  logic             fin;
  mf5_pkg::cnt_t    n_res;
  mf5_pkg::result_t res_a;
  mf5_pkg::result_t res_b;
  mf5_pkg::result_t res_c;
  mf5_pkg::result_t new_slot [mf5_pkg::SLOTS];

  assign accept   = samples.valid && samples.ready;
  assign pop      = results.valid && results.ready;
  assign at_start = (pos == '0);
  assign past_lim = (pos >= mf5_pkg::POS_W'(mf5_pkg::MAX_BLOCK));

  // medians and result list of the staged item
  always_comb begin
    fin   = s1_last || s1_lim;
    med_a = mf5_pkg::median5(s1_h[3], s1_h[2], s1_h[1], s1_h[0], s1_x);
    med_b = mf5_pkg::median5(s1_h[2], s1_h[1], s1_h[0], s1_x, s1_x);
    med_c = mf5_pkg::median5(s1_h[1], s1_h[0], s1_x, s1_x, s1_x);
    res_a = '{value: med_a, done: 1'b0};
    res_b = '{value: med_b, done: 1'b0};
    res_c = '{value: med_c, done: s1_last};
    new_slot[0] = res_c;
    new_slot[1] = res_c;
    new_slot[2] = res_c;
    n_res       = '0;
    if (s1_pass) begin
      new_slot[0] = '{value: s1_x, done: s1_last};
      n_res       = mf5_pkg::CNT_W'(1);
    end else if (s1_ge2) begin
      new_slot[0] = res_a;
      new_slot[1] = res_b;
      n_res       = fin ? mf5_pkg::CNT_W'(3) : mf5_pkg::CNT_W'(1);
    end else if (fin && s1_ge1) begin
      new_slot[0] = res_b;
      n_res       = mf5_pkg::CNT_W'(2);
    end else if (fin) begin
      n_res       = mf5_pkg::CNT_W'(1);
    end
  end

  assign buf_free      = (cnt == '0) || ((cnt == mf5_pkg::CNT_W'(1)) && results.ready);
  assign s1_adv        = s1_valid && ((n_res == '0) || buf_free);
  assign load          = s1_adv && (n_res != '0);
  assign samples.ready = !s1_valid || s1_adv;

  assign results.valid      = (cnt != '0);
  assign results.sample_out = slot[0].value;
  assign results.block_done = slot[0].done;

  // history and position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      for (int k = 0; k < 4; k++) hist[k] <= '0;
    end else if (accept) begin
      if (past_lim) begin
        pos <= samples.block_end ? '0 : mf5_pkg::POS_W'(mf5_pkg::MAX_BLOCK);
      end else begin
        pos     <= samples.block_end ? '0 : pos + mf5_pkg::POS_W'(1);
        hist[0] <= samples.sample_in;
        hist[1] <= at_start ? samples.sample_in : hist[0];
        hist[2] <= at_start ? samples.sample_in : hist[1];
        hist[3] <= at_start ? samples.sample_in : hist[2];
      end
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x    <= samples.sample_in;
      s1_last <= samples.block_end;
      s1_pass <= past_lim;
      s1_ge1  <= !at_start;
      s1_ge2  <= (pos >= mf5_pkg::POS_W'(2));
      s1_lim  <= (pos == mf5_pkg::POS_W'(mf5_pkg::MAX_BLOCK - 1));
      for (int k = 0; k < 4; k++) begin
        s1_h[k] <= at_start ? samples.sample_in : hist[k];
      end
    end
  end

  // result buffer: head at slot 0, shifts on each delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= n_res;
    end else if (pop) begin
      cnt <= cnt - mf5_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < mf5_pkg::SLOTS; k++) slot[k] <= new_slot[k];
    end else if (pop) begin
      for (int k = 0; k < mf5_pkg::SLOTS - 1; k++) slot[k] <= slot[k + 1];
    end
  end

endmodule

// File: hdl/mf5_checker.sv
// Port-level assertions for the median filter, bound to the top level.
module mf5_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input mf5_pkg::sample_t sample_out,
  input logic             block_done
);

  // reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // reset leaves the input side open
  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // input only backs up behind a pending result
  a_no_deadlock: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(block_done))
    else $error("stalled result changed");

endmodule

bind median_filter_5tap mf5_checker u_mf5_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (samples.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .sample_out (results.sample_out),
  .block_done (results.block_done)
);

// File: test/median_filter_5tap_tb.sv
`timescale 1ns / 100ps
// Stand-alone testbench for the five-tap block median filter with a built-in predictor.
module median_filter_5tap_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_PER_PHASE = 70;
  localparam int MAX_PRINTS = 60;

  typedef struct packed {
    mf5_pkg::sample_t value;
    logic             last;
  } sample_req_t;

  logic clk;
  logic rst;

  mf5_in_if  samples ();
  mf5_out_if results ();

  median_filter_5tap u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results)
  );

  sample_req_t      pending_q[$];
  mf5_pkg::result_t filtered_q[$];
  sample_req_t      on_bus;
  mf5_pkg::result_t want;

  // filter state as seen by the predictor
  mf5_pkg::sample_t taps [4];
  int               blk_pos;

  int send_idle_pct;
  int recv_stall_pct;
  bit rx_hold;
  int err_cnt;
  int cycle_cnt;
  int samples_taken;
  int results_checked;
  int blocks_sent;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic mf5_pkg::sample_t mid_of_five(mf5_pkg::sample_t a, mf5_pkg::sample_t b,
                                                   mf5_pkg::sample_t c, mf5_pkg::sample_t d,
                                                   mf5_pkg::sample_t e);
    mf5_pkg::sample_t w [5];
    int lt;
    int le;
    w[0] = a;
    w[1] = b;
    w[2] = c;
    w[3] = d;
    w[4] = e;
    // the median is the value with at most two below it and at least three at or below
    for (int i = 0; i < 5; i++) begin
      lt = 0;
      le = 0;
      for (int j = 0; j < 5; j++) begin
        if (w[j] < w[i]) lt++;
        if (w[j] <= w[i]) le++;
      end
      if (lt <= 2 && le >= 3) return w[i];
    end
    return w[0];
  endfunction

  function automatic mf5_pkg::result_t mk_result(mf5_pkg::sample_t v, logic d);
    mf5_pkg::result_t r;
    r.value = v;
    r.done  = d;
    return r;
  endfunction

  task automatic predict_filter(mf5_pkg::sample_t x, logic last);
    mf5_pkg::sample_t h0;
    mf5_pkg::sample_t h1;
    mf5_pkg::sample_t h2;
    mf5_pkg::sample_t h3;
    if (blk_pos >= mf5_pkg::MAX_BLOCK) begin
      filtered_q.push_back(mk_result(x, last));
      blk_pos = last ? 0 : mf5_pkg::MAX_BLOCK;
      return;
    end
    if (blk_pos == 0) begin
      for (int k = 0; k < 4; k++) taps[k] = x;
    end
    h0 = taps[0];
    h1 = taps[1];
    h2 = taps[2];
    h3 = taps[3];
    if (blk_pos >= 2) filtered_q.push_back(mk_result(mid_of_five(h3, h2, h1, h0, x), 1'b0));
    // block end (flagged or at the limit) flushes the trailing windows (one for a block's first sample)
    if (last || blk_pos == mf5_pkg::MAX_BLOCK - 1) begin
      if (blk_pos >= 1)
        filtered_q.push_back(mk_result(mid_of_five(h2, h1, h0, x, x), 1'b0));
      filtered_q.push_back(mk_result(mid_of_five(h1, h0, x, x, x), last));
    end
    taps[3] = h2;
    taps[2] = h1;
    taps[1] = h0;
    taps[0] = x;
    blk_pos = last ? 0 : blk_pos + 1;
  endtask

  task automatic report_mismatch(string what);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic mf5_pkg::sample_t rand_sample();
    case ($urandom_range(9))
      0: return mf5_pkg::sample_t'(16'h7fff);
      1: return mf5_pkg::sample_t'(16'h8000);
      2: return '0;
      3, 4: return mf5_pkg::sample_t'($urandom_range(7) - 4);  // narrow range, lots of ties
      default: return mf5_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic push_sample(mf5_pkg::sample_t v, logic last);
    sample_req_t r;
    r.value = v;
    r.last  = last;
    pending_q.push_back(r);
  endtask

  task automatic push_block(int len);
    for (int k = 0; k < len; k++) push_sample(rand_sample(), k == len - 1);
    blocks_sent++;
  endtask

  task automatic push_random_blocks(int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      push_block(len);
      n += len;
    end
  endtask

  task automatic wait_sent();
    while (pending_q.size() != 0 || samples.valid) @(posedge clk);
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      samples.valid     <= 1'b0;
      samples.sample_in <= '0;
      samples.block_end <= 1'b0;
    end else begin
      if (samples.valid && samples.ready) begin
        predict_filter(on_bus.value, on_bus.last);
        samples_taken++;
      end
      if (!samples.valid || samples.ready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = pending_q.pop_front();
          samples.valid     <= 1'b1;
          samples.sample_in <= on_bus.value;
          samples.block_end <= on_bus.last;
        end else begin
          samples.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        results_checked++;
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d done %0b",
                                    results.sample_out, results.block_done));
        end else begin
          want = filtered_q.pop_front();
          if (results.sample_out !== want.value)
            report_mismatch($sformatf("result %0d: sample_out %0d, want %0d",
                                      results_checked, results.sample_out, want.value));
          if (results.block_done !== want.done)
            report_mismatch($sformatf("result %0d: block_done %0b, want %0b",
                                      results_checked, results.block_done, want.done));
        end
      end
      results.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off right after reset, so the input side backs up
  initial begin
    rx_hold = 1'b0;
    wait (rst === 1'b0);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt, filtered_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    blk_pos        = 0;
    for (int k = 0; k < 4; k++) taps[k] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: short blocks, extremes, ties
    push_sample(mf5_pkg::sample_t'(16'h7fff), 1'b1);
    push_sample(mf5_pkg::sample_t'(16'h8000), 1'b0);
    push_sample(mf5_pkg::sample_t'(16'h7fff), 1'b1);
    push_sample(mf5_pkg::sample_t'(16'h8000), 1'b0);
    push_sample(mf5_pkg::sample_t'(-1), 1'b0);
    push_sample(mf5_pkg::sample_t'(16'h7fff), 1'b1);
    push_sample(mf5_pkg::sample_t'(16'h7fff), 1'b0);
    push_sample(mf5_pkg::sample_t'(16'h8000), 1'b0);
    push_sample('0, 1'b0);
    push_sample(mf5_pkg::sample_t'(16'h8000), 1'b0);
    push_sample(mf5_pkg::sample_t'(16'h7fff), 1'b1);
    push_sample(mf5_pkg::sample_t'(5), 1'b0);
    push_sample(mf5_pkg::sample_t'(5), 1'b0);
    push_sample(mf5_pkg::sample_t'(-5), 1'b0);
    push_sample(mf5_pkg::sample_t'(5), 1'b0);
    push_sample(mf5_pkg::sample_t'(-5), 1'b0);
    push_sample(mf5_pkg::sample_t'(-5), 1'b1);
    push_sample(mf5_pkg::sample_t'(16'h5555), 1'b0);
    push_sample(mf5_pkg::sample_t'(16'haaaa), 1'b0);
    push_sample(mf5_pkg::sample_t'(16'h0001), 1'b0);
    push_sample(mf5_pkg::sample_t'(16'hfffe), 1'b1);
    blocks_sent += 6;

    // no idling on either side
    push_random_blocks(RAND_PER_PHASE);
    wait_sent();

    // sender idles
    send_idle_pct = 58;
    push_random_blocks(RAND_PER_PHASE);
    wait_sent();

    // receiver stalls
    send_idle_pct  = 0;
    recv_stall_pct = 58;
    push_random_blocks(RAND_PER_PHASE);
    wait_sent();

    // both idle
    send_idle_pct  = 31;
    recv_stall_pct = 31;
    push_random_blocks(RAND_PER_PHASE);
    wait_sent();

    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (filtered_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", filtered_q.size()));

    $display("covered %0d samples in %0d blocks, %0d filtered results compared",
             samples_taken, blocks_sent, results_checked);
    $display("idle mixes: none, sender, receiver, both; one long hold-off; %0d mismatches",
             err_cnt);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
